FILE: src/xorshift16_ranged_random_defines.svh
// ----------------------------------------------------------------------------
// xorshift16 ranged random - assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef XORSHIFT16_RANGED_RANDOM_DEFINES_SVH
`define XORSHIFT16_RANGED_RANDOM_DEFINES_SVH

// same-cycle implication
`define XSR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define XSR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/xsr_pkg.sv
// ----------------------------------------------------------------------------
// xsr_pkg
// types, codes and helpers of the ranged xorshift16 generator
// ----------------------------------------------------------------------------
package xsr_pkg;

	localparam int unsigned SHIFT_A = 7;
	localparam int unsigned SHIFT_B = 9;
	localparam int unsigned SHIFT_C = 8;

	typedef enum logic [1:0] {
		REQ_SEED = 2'd0,
		REQ_RAW  = 2'd1,
		REQ_MOD  = 2'd2,
		REQ_MASK = 2'd3
	} xsr_req_type_t;

	typedef struct packed {
		xsr_req_type_t req_type;
		logic [15:0]   seed_value;
		logic [7:0]    bound;
		logic [3:0]    bit_count;
	} xsr_req_t;

	typedef struct packed {
		logic [15:0] value;
		logic        bad_bound;
	} xsr_rsp_t;

	typedef struct packed {
		logic load;
		logic step;
		logic div;
		logic out_load;
	} xsr_cmd_t;

	typedef struct packed {
		logic need_div;
	} xsr_sts_t;

	function automatic logic [7:0] mask_for(input logic [3:0] n);
		logic [7:0] m;
		case (n)
			4'd0, 4'd1: m = 8'h01;
			4'd2:       m = 8'h03;
			4'd3:       m = 8'h07;
			4'd4:       m = 8'h0f;
			4'd5:       m = 8'h1f;
			4'd6:       m = 8'h3f;
			4'd7:       m = 8'h7f;
			default:    m = 8'hff;
		endcase
		return m;
	endfunction

endpackage

FILE: src/xsr_datapath.sv
// ----------------------------------------------------------------------------
// xsr_datapath
// generator state, xorshift step, restoring remainder unit, result register
// ----------------------------------------------------------------------------
module xsr_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  xsr_pkg::xsr_req_t req,
	input  xsr_pkg::xsr_cmd_t cmd,
	output xsr_pkg::xsr_sts_t sts,
	output xsr_pkg::xsr_rsp_t rsp
);
	import xsr_pkg::*;

	xsr_req_t    item_q;
	logic [15:0] gen_q;
	logic [7:0]  rem_q;
	logic [7:0]  dvd_q;
	xsr_rsp_t    res_q;
	xsr_rsp_t    out_q;

	logic [15:0] s1, s2, s3;
	logic [15:0] nxt_state;
	logic [7:0]  low;
	logic [8:0]  trial;
	logic [8:0]  diff;
	logic [7:0]  rem_nxt;
	xsr_rsp_t    res_nxt;

	always_comb begin
		s1 = gen_q ^ (gen_q << SHIFT_A);
		s2 = s1 ^ (s1 >> SHIFT_B);
		s3 = s2 ^ (s2 << SHIFT_C);
		nxt_state = (item_q.req_type == REQ_SEED) ? item_q.seed_value : s3;
		low = nxt_state[7:0];
	end

	always_comb begin
		trial = {rem_q, dvd_q[7]};
		diff = trial - {1'b0, item_q.bound};
		rem_nxt = (trial >= {1'b0, item_q.bound}) ? diff[7:0] : trial[7:0];
	end

	always_comb begin
		res_nxt = '0;
		case (item_q.req_type)
			REQ_SEED: res_nxt.value = item_q.seed_value;
			REQ_RAW:  res_nxt.value = nxt_state;
			REQ_MOD:  res_nxt.bad_bound = (item_q.bound == 8'd0);
			REQ_MASK: res_nxt.value = {8'h00, low & mask_for(item_q.bit_count)};
			default:  res_nxt = '0;
		endcase
	end

	assign sts.need_div = (item_q.req_type == REQ_MOD) && (item_q.bound != 8'd0);
	assign rsp = out_q;

	// generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= '0;
		end else if (cmd.step) begin
			gen_q <= nxt_state;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= req;
		end
		if (cmd.step) begin
			res_q <= res_nxt;
			rem_q <= '0;
			dvd_q <= low;
		end else if (cmd.div) begin
			rem_q <= rem_nxt;
			dvd_q <= {dvd_q[6:0], 1'b0};
		end
		if (cmd.out_load) begin
			if (sts.need_div) begin
				out_q <= '{value: {8'h00, rem_q}, bad_bound: 1'b0};
			end else begin
				out_q <= res_q;
			end
		end
	end

endmodule

FILE: src/xsr_ctrl.sv
// ----------------------------------------------------------------------------
// xsr_ctrl
// request sequencer: accept, step, remainder iterations, result hand-off
// ----------------------------------------------------------------------------
module xsr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  xsr_pkg::xsr_sts_t sts,
	output xsr_pkg::xsr_cmd_t cmd
);
	import xsr_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_STEP,
		S_DIV,
		S_DONE
	} state_t;

	state_t     state_q;
	logic [2:0] cnt_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd.load = (state_q == S_IDLE) && req_valid;
		cmd.step = (state_q == S_STEP);
		cmd.div = (state_q == S_DIV);
		cmd.out_load = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					cnt_q <= '0;
					state_q <= sts.need_div ? S_DIV : S_DONE;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd7) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: src/xorshift16_ranged_random.sv
// ----------------------------------------------------------------------------
// xorshift16_ranged_random
// 16-bit xorshift (7, 9, 8) generator with reseed, raw, modulo and mask requests
// ----------------------------------------------------------------------------
// channel  direction  handshake            beat
// req      in         req_valid/req_stall  req_type, seed_value, bound, bit_count
// rsp      out        rsp_valid/rsp_stall  value, bad_bound
//
// one request at a time: an accepted request is registered, then stepped into
// the result register; a modulo request with a nonzero bound then runs 8
// restoring remainder steps; rsp_valid rises once the result is loaded
// req_stall is high from accept until the result enters the output register
// a waiting result does not block the next accept; a stalled rsp holds it
// reset clears the generator state to zero and drops rsp_valid
// ----------------------------------------------------------------------------
module xorshift16_ranged_random (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  xsr_pkg::xsr_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output xsr_pkg::xsr_rsp_t rsp
);
	import xsr_pkg::*;

	xsr_cmd_t cmd;
	xsr_sts_t sts;

	xsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	xsr_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

FILE: src/xsr_checker.sv
// ----------------------------------------------------------------------------
// xsr_checker
// port-level checks of the ranged xorshift16 generator
// ----------------------------------------------------------------------------
`include "xorshift16_ranged_random_defines.svh"

module xsr_port_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input xsr_pkg::xsr_req_t req,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input xsr_pkg::xsr_rsp_t rsp
);
	import xsr_pkg::*;

	// stalled result beat holds
	`XSR_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp beat changed under stall")

	// one request in flight
	`XSR_ASSERT_NXT(a_busy_after_accept, clk, arst_n, req_valid && !req_stall, req_stall, "req accepted while busy")

	// a bad bound result carries zero
	`XSR_ASSERT_IMP(a_bad_bound_zero, clk, arst_n, rsp_valid && rsp.bad_bound, rsp.value == 16'd0, "bad bound with nonzero value")

	// no result right after an accept
	`XSR_ASSERT_IMP(a_no_early_rsp, clk, arst_n, $rose(rsp_valid), !$past(req_valid && !req_stall), "result too soon after accept")

endmodule

bind xorshift16_ranged_random xsr_port_checker u_chk (.*);
